// ----- design/bdar_pkg.sv -----
package bdar_pkg;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned SAMPLE_W = 10;
    localparam int unsigned DEB_W    = 16;
    localparam int unsigned COUNT_W  = 2;
    localparam int unsigned IDX_W    = 3;
    localparam int unsigned DATA_W   = 32;

    localparam logic [SAMPLE_W-1:0] THRESHOLD_RST = SAMPLE_W'(200);
    localparam logic [DEB_W-1:0]    DEBOUNCE_RST  = DEB_W'(100);
    localparam logic [TIME_W-1:0]   REPEAT_RST    = TIME_W'(300);
    localparam logic [TIME_W-1:0]   START_RST     = TIME_W'(500);

    typedef enum logic [IDX_W-1:0] {
        CFG_ANALOG_MODE  = 3'd0,
        CFG_THRESHOLD    = 3'd1,
        CFG_DEBOUNCE     = 3'd2,
        CFG_REPEAT       = 3'd3,
        CFG_START_DELAY  = 3'd4,
        CFG_PRESS_EN     = 3'd5,
        CFG_DOWN_EN      = 3'd6,
        CFG_UP_EN        = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic                analog_mode;
        logic [SAMPLE_W-1:0] analog_threshold;
        logic [DEB_W-1:0]    debounce_ms;
        logic [TIME_W-1:0]   repeat_ms;
        logic [TIME_W-1:0]   start_delay_ms;
        logic                press_enable;
        logic                down_enable;
        logic                up_enable;
    } t_cfg;

    typedef struct packed {
        logic [TIME_W-1:0]   time_ms;
        logic                digital_level;
        logic [SAMPLE_W-1:0] analog_sample;
    } t_poll;

    typedef struct packed {
        logic               key_down;
        logic [COUNT_W-1:0] key_press_count;
        logic               key_up;
        logic               is_held;
        logic [TIME_W-1:0]  press_time_ms;
    } t_result;

endpackage

// ----- design/bdar_if.sv -----
interface bdar_in_if;
    logic                           valid;
    logic                           ready;
    logic [bdar_pkg::TIME_W-1:0]    time_ms;
    logic                           digital_level;
    logic [bdar_pkg::SAMPLE_W-1:0]  analog_sample;

    modport source (output valid, time_ms, digital_level, analog_sample, input ready);
    modport sink   (input valid, time_ms, digital_level, analog_sample, output ready);
endinterface

interface bdar_out_if;
    logic                           valid;
    logic                           ready;
    logic                           key_down;
    logic [bdar_pkg::COUNT_W-1:0]   key_press_count;
    logic                           key_up;
    logic                           is_held;
    logic [bdar_pkg::TIME_W-1:0]    press_time_ms;

    modport source (output valid, key_down, key_press_count, key_up, is_held,
                    press_time_ms, input ready);
    modport sink   (input valid, key_down, key_press_count, key_up, is_held,
                    press_time_ms, output ready);
endinterface

interface bdar_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [bdar_pkg::IDX_W-1:0]     index;
    logic [bdar_pkg::DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/bdar_cfg.sv -----
module bdar_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_we,
    input  logic [bdar_pkg::IDX_W-1:0]   i_index,
    input  logic [bdar_pkg::DATA_W-1:0]  i_data,
    output bdar_pkg::t_cfg               o_cfg
);
    import bdar_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.analog_mode      <= 1'b0;
            r_cfg.analog_threshold <= THRESHOLD_RST;
            r_cfg.debounce_ms      <= DEBOUNCE_RST;
            r_cfg.repeat_ms        <= REPEAT_RST;
            r_cfg.start_delay_ms   <= START_RST;
            r_cfg.press_enable     <= 1'b1;
            r_cfg.down_enable      <= 1'b0;
            r_cfg.up_enable        <= 1'b0;
        end else if (i_we) begin
            case (t_cfg_idx'(i_index))
                CFG_ANALOG_MODE: r_cfg.analog_mode      <= i_data[0];
                CFG_THRESHOLD:   r_cfg.analog_threshold <= i_data[SAMPLE_W-1:0];
                CFG_DEBOUNCE:    r_cfg.debounce_ms      <= i_data[DEB_W-1:0];
                CFG_REPEAT:      r_cfg.repeat_ms        <= i_data[TIME_W-1:0];
                CFG_START_DELAY: r_cfg.start_delay_ms   <= i_data[TIME_W-1:0];
                CFG_PRESS_EN:    r_cfg.press_enable     <= i_data[0];
                CFG_DOWN_EN:     r_cfg.down_enable      <= i_data[0];
                CFG_UP_EN:       r_cfg.up_enable        <= i_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- design/bdar_track.sv -----
module bdar_track (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bdar_pkg::t_cfg     i_cfg,
    input  logic               i_step,
    input  bdar_pkg::t_poll    i_poll,
    output bdar_pkg::t_result  o_result
);
    import bdar_pkg::*;

    logic              r_acc_level;
    logic [TIME_W-1:0] r_last_change;
    logic [TIME_W-1:0] r_press_start;
    logic [TIME_W-1:0] r_last_event;
    logic              r_held;

    logic              n_acc_level;
    logic [TIME_W-1:0] n_last_change;
    logic [TIME_W-1:0] n_press_start;
    logic [TIME_W-1:0] n_last_event;
    logic              n_held;

    logic              cur;
    logic              changed;
    logic              rejected;
    logic [TIME_W-1:0] since_change;
    logic [TIME_W-1:0] held_time;
    logic [TIME_W-1:0] since_event;
    logic              repeat_on;
    logic              first_press;
    logic              repeat_press;

    always_comb begin
        cur          = i_cfg.analog_mode ? (i_poll.analog_sample > i_cfg.analog_threshold)
                                         : i_poll.digital_level;
        changed      = (cur != r_acc_level);
        since_change = i_poll.time_ms - r_last_change;
        rejected     = changed && (since_change < {{(TIME_W-DEB_W){1'b0}}, i_cfg.debounce_ms});
        repeat_on    = (i_cfg.repeat_ms != '0) && i_cfg.press_enable;

        n_acc_level   = r_acc_level;
        n_last_change = r_last_change;
        n_press_start = r_press_start;
        n_last_event  = r_last_event;
        n_held        = r_held;
        first_press   = 1'b0;
        repeat_press  = 1'b0;
        o_result.key_down = 1'b0;
        o_result.key_up   = 1'b0;

        // a fresh press starts its hold clock at this poll
        held_time   = r_held ? (i_poll.time_ms - r_press_start) : '0;
        since_event = i_poll.time_ms - r_last_event;

        if (!rejected) begin
            n_acc_level = cur;
            if (changed) begin
                n_last_change = i_poll.time_ms;
            end
            if (!cur) begin
                if (!r_held) begin
                    n_held            = 1'b1;
                    n_press_start     = i_poll.time_ms;
                    o_result.key_down = i_cfg.down_enable;
                    first_press       = i_cfg.press_enable;
                end
                if (repeat_on) begin
                    if (held_time >= i_cfg.start_delay_ms) begin
                        if (since_event > i_cfg.repeat_ms) begin
                            n_last_event = i_poll.time_ms;
                            repeat_press = 1'b1;
                        end
                    end else begin
                        n_last_event = i_poll.time_ms;
                    end
                end
            end else begin
                n_last_event = '0;
                if (r_held) begin
                    o_result.key_up = i_cfg.up_enable;
                    n_held          = 1'b0;
                    n_press_start   = '0;
                end
            end
        end

        o_result.key_press_count = {1'b0, first_press} + {1'b0, repeat_press};
        o_result.is_held         = n_held;
        o_result.press_time_ms   = n_held ? (i_poll.time_ms - n_press_start) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_level   <= 1'b1;
            r_last_change <= '0;
            r_press_start <= '0;
            r_last_event  <= '0;
            r_held        <= 1'b0;
        end else if (i_step) begin
            r_acc_level   <= n_acc_level;
            r_last_change <= n_last_change;
            r_press_start <= n_press_start;
            r_last_event  <= n_last_event;
            r_held        <= n_held;
        end
    end

endmodule

// ----- design/button_debounce_autorepeat.sv -----
// Debounced active-low key with typematic auto-repeat.
// i_in carries one poll per beat: millisecond timestamp, raw pin level and
// a 10-bit analog sample. o_out returns exactly one result beat per poll:
// key-down, key-press count (0..2), key-up, held flag and press duration.
// i_cfg writes one of eight setup registers by index; it is always ready and
// should only be used while no poll is in flight.
// A poll accepted at one edge is registered in the input register, evaluated
// against the tracking state once it can advance, and its result is
// registered in the result register at the edge that advances it. One poll
// per cycle is sustained while o_out.ready stays high; the only loop is the
// tracking-state update, written at that same edge.
// Reset (synchronous, active low) loads the register defaults, marks the key
// released and not held, and empties both pipeline registers.
// If the receiver stalls, the result register holds its beat, the input
// register still takes one more poll, and then i_in.ready drops until the
// result is taken.
module button_debounce_autorepeat (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bdar_in_if.sink    i_in,
    bdar_out_if.source o_out,
    bdar_cfg_if.sink   i_cfg
);
    import bdar_pkg::*;

    t_cfg    cfg;
    t_poll   poll_in;
    t_result step_result;

    logic    r_s1_valid;
    t_poll   r_s1_poll;
    logic    r_out_valid;
    t_result r_out_result;

    logic    advance;
    logic    in_take;

    assign advance = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_s1_valid || advance;
    assign in_take     = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    assign poll_in.time_ms       = i_in.time_ms;
    assign poll_in.digital_level = i_in.digital_level;
    assign poll_in.analog_sample = i_in.analog_sample;

    bdar_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg.valid),
        .i_index (i_cfg.index),
        .i_data  (i_cfg.data),
        .o_cfg   (cfg)
    );

    bdar_track u_track (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_step   (advance),
        .i_poll   (r_s1_poll),
        .o_result (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_s1_valid <= 1'b1;
            end else if (advance) begin
                r_s1_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers: load on their own handshakes only
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_poll <= poll_in;
        end
        if (advance) begin
            r_out_result <= step_result;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.key_down        = r_out_result.key_down;
    assign o_out.key_press_count = r_out_result.key_press_count;
    assign o_out.key_up          = r_out_result.key_up;
    assign o_out.is_held         = r_out_result.is_held;
    assign o_out.press_time_ms   = r_out_result.press_time_ms;

endmodule
